>>> design/kdll_pkg.sv
`default_nettype none

package kdll_pkg;

	localparam int KEY_W  = 10;
	localparam int ACT_W  = 3;
	localparam int STAT_W = 2;

	// Request codes.
	localparam logic [ACT_W-1:0] ACT_ADD       = 3'd0;
	localparam logic [ACT_W-1:0] ACT_DELETE    = 3'd1;
	localparam logic [ACT_W-1:0] ACT_POP_HEAD  = 3'd2;
	localparam logic [ACT_W-1:0] ACT_POP_TAIL  = 3'd3;
	localparam logic [ACT_W-1:0] ACT_READ_HEAD = 3'd4;
	localparam logic [ACT_W-1:0] ACT_READ_TAIL = 3'd5;

	// Result codes.
	localparam logic [STAT_W-1:0] STATUS_DONE    = 2'd0;
	localparam logic [STAT_W-1:0] STATUS_IGNORED = 2'd1;
	localparam logic [STAT_W-1:0] STATUS_EMPTY   = 2'd2;
	localparam logic [STAT_W-1:0] STATUS_FULL    = 2'd3;

	typedef struct packed {
		logic [ACT_W-1:0] action;
		logic [KEY_W-1:0] key;
	} req_t;

	typedef struct packed {
		logic [KEY_W-1:0]  key_out;
		logic [STAT_W-1:0] status;
	} rsp_t;

	// Datapath operations, one per cycle, chosen by the controller.
	typedef enum logic [3:0] {
		DP_NOP,
		DP_CLEAR,
		DP_LOAD,
		DP_MAP_RD,
		DP_ADD,
		DP_ADD_LINK,
		DP_NODE_RD_MAP,
		DP_NODE_RD_END,
		DP_UNLINK_KEY,
		DP_UNLINK_NODE,
		DP_GET_KEY,
		DP_OUT
	} dp_step_t;

	typedef struct packed {
		dp_step_t          step;
		logic              from_head;
		logic [STAT_W-1:0] status;
	} cmd_t;

	typedef struct packed {
		logic clear_last;
		logic key_ok;
		logic map_hit;
		logic slots_full;
		logic list_empty;
	} stat_t;

endpackage

`default_nettype wire

>>> design/kdll_datapath.sv
`default_nettype none

module kdll_datapath #(
	parameter int NUM_SLOTS = 1024,
	parameter int KEY_RANGE = 1024
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire kdll_pkg::cmd_t              cmd,
	input  wire logic [kdll_pkg::KEY_W-1:0]  key,
	output kdll_pkg::stat_t                  stat,
	output kdll_pkg::rsp_t                   rsp
);

	localparam int KEY_W     = kdll_pkg::KEY_W;
	localparam int SW        = $clog2(NUM_SLOTS + 1);
	localparam int SIW       = $clog2(NUM_SLOTS);
	localparam int MAP_DEPTH = (KEY_RANGE < (1 << KEY_W)) ? KEY_RANGE : (1 << KEY_W);
	localparam int MAW       = $clog2(MAP_DEPTH);
	localparam logic [SW-1:0]  NULL_SLOT = SW'(NUM_SLOTS);
	localparam logic [MAW-1:0] CLR_LAST  = MAW'(MAP_DEPTH - 1);

	logic [KEY_W-1:0] key_mem  [NUM_SLOTS];
	logic [SW-1:0]    next_mem [NUM_SLOTS];
	logic [SW-1:0]    prev_mem [NUM_SLOTS];
	logic [SW-1:0]    map_mem  [MAP_DEPTH];

	logic [SW-1:0]    head_q, tail_q, free_q, slot_q, link_q;
	logic [MAW-1:0]   clr_q;
	logic [KEY_W-1:0] key_q, kout_q, key_rd_q;
	logic [SW-1:0]    prev_rd_q, next_rd_q, map_rd_q;
	kdll_pkg::rsp_t   rsp_q;

	logic             add_ok, node_rd_en;
	logic [SW-1:0]    rd_slot;
	logic             key_we, next_we, prev_we, map_we;
	logic [SIW-1:0]   key_wa, next_wa, prev_wa;
	logic [MAW-1:0]   map_wa;
	logic [KEY_W-1:0] key_wd;
	logic [SW-1:0]    next_wd, prev_wd, map_wd;

	function automatic logic is_slot(input logic [SW-1:0] s);
		return 32'(s) < NUM_SLOTS;
	endfunction

	assign stat.clear_last = (clr_q == CLR_LAST);
	assign stat.key_ok     = 32'(key_q) < KEY_RANGE;
	assign stat.map_hit    = is_slot(map_rd_q);
	assign stat.slots_full = !is_slot(free_q);
	assign stat.list_empty = !is_slot(head_q);
	assign add_ok          = !stat.map_hit && !stat.slots_full;
	assign rsp             = rsp_q;

	assign node_rd_en = (cmd.step == kdll_pkg::DP_NODE_RD_MAP) ||
	                    (cmd.step == kdll_pkg::DP_NODE_RD_END);

	always_comb begin
		if (cmd.step == kdll_pkg::DP_NODE_RD_MAP) begin
			rd_slot = map_rd_q;
		end else if (cmd.from_head) begin
			rd_slot = head_q;
		end else begin
			rd_slot = tail_q;
		end
	end

	// Write ports of the four memories.
	always_comb begin
		key_we  = 1'b0;
		key_wa  = free_q[SIW-1:0];
		key_wd  = key_q;
		next_we = 1'b0;
		next_wa = free_q[SIW-1:0];
		next_wd = NULL_SLOT;
		prev_we = 1'b0;
		prev_wa = free_q[SIW-1:0];
		prev_wd = tail_q;
		map_we  = 1'b0;
		map_wa  = key_q[MAW-1:0];
		map_wd  = NULL_SLOT;
		unique case (cmd.step)
			kdll_pkg::DP_CLEAR: begin
				map_we = 1'b1;
				map_wa = clr_q;
			end
			kdll_pkg::DP_ADD: begin
				key_we  = add_ok;
				next_we = add_ok;
				prev_we = add_ok;
				map_we  = add_ok;
				map_wd  = free_q;
			end
			kdll_pkg::DP_ADD_LINK: begin
				next_we = is_slot(link_q);
				next_wa = link_q[SIW-1:0];
				next_wd = slot_q;
			end
			kdll_pkg::DP_UNLINK_KEY, kdll_pkg::DP_UNLINK_NODE: begin
				next_we = is_slot(prev_rd_q);
				next_wa = prev_rd_q[SIW-1:0];
				next_wd = next_rd_q;
				prev_we = is_slot(next_rd_q);
				prev_wa = next_rd_q[SIW-1:0];
				prev_wd = prev_rd_q;
				map_we  = 1'b1;
				if (cmd.step == kdll_pkg::DP_UNLINK_NODE) begin
					map_wa = key_rd_q[MAW-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (key_we) begin
			key_mem[key_wa] <= key_wd;
		end
		if (next_we) begin
			next_mem[next_wa] <= next_wd;
		end
		if (prev_we) begin
			prev_mem[prev_wa] <= prev_wd;
		end
		if (map_we) begin
			map_mem[map_wa] <= map_wd;
		end
		if (node_rd_en) begin
			key_rd_q  <= key_mem[rd_slot[SIW-1:0]];
			next_rd_q <= next_mem[rd_slot[SIW-1:0]];
			prev_rd_q <= prev_mem[rd_slot[SIW-1:0]];
		end
		if (cmd.step == kdll_pkg::DP_MAP_RD) begin
			map_rd_q <= map_mem[key_q[MAW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.step)
			kdll_pkg::DP_LOAD: begin
				key_q  <= key;
				kout_q <= '0;
			end
			kdll_pkg::DP_ADD: begin
				slot_q <= free_q;
				link_q <= tail_q;
			end
			kdll_pkg::DP_UNLINK_NODE, kdll_pkg::DP_GET_KEY: begin
				kout_q <= key_rd_q;
			end
			kdll_pkg::DP_OUT: begin
				rsp_q.key_out <= kout_q;
				rsp_q.status  <= cmd.status;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= NULL_SLOT;
			tail_q <= NULL_SLOT;
			free_q <= '0;
			clr_q  <= '0;
		end else begin
			unique case (cmd.step)
				kdll_pkg::DP_CLEAR: begin
					clr_q <= clr_q + 1'b1;
				end
				kdll_pkg::DP_ADD: begin
					if (add_ok) begin
						tail_q <= free_q;
						free_q <= free_q + 1'b1;
						if (!is_slot(head_q)) begin
							head_q <= free_q;
						end
					end
				end
				kdll_pkg::DP_UNLINK_KEY, kdll_pkg::DP_UNLINK_NODE: begin
					if (!is_slot(prev_rd_q)) begin
						head_q <= next_rd_q;
					end
					if (!is_slot(next_rd_q)) begin
						tail_q <= prev_rd_q;
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

`default_nettype wire

>>> design/kdll_ctrl.sv
`default_nettype none

module kdll_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            req_valid,
	output logic                 req_ready,
	input  wire logic [kdll_pkg::ACT_W-1:0] req_action,
	output logic                 rsp_valid,
	input  wire logic            rsp_ready,
	input  wire kdll_pkg::stat_t stat,
	output kdll_pkg::cmd_t       cmd
);

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_MAP_RD,
		S_ADD,
		S_ADD_LINK,
		S_DEL_RD,
		S_UNLINK_KEY,
		S_NODE_RD,
		S_UNLINK_NODE,
		S_GET_KEY,
		S_OUT
	} state_t;

	state_t                       state_q;
	logic                         is_add_q, is_pop_q, from_head_q, out_valid_q;
	logic [kdll_pkg::STAT_W-1:0]  status_q;
	logic                         out_free;

	assign out_free  = !out_valid_q || rsp_ready;
	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = out_valid_q;

	always_comb begin
		cmd.from_head = from_head_q;
		cmd.status    = status_q;
		unique case (state_q)
			S_CLEAR:       cmd.step = kdll_pkg::DP_CLEAR;
			S_IDLE:        cmd.step = kdll_pkg::DP_LOAD;
			S_MAP_RD:      cmd.step = kdll_pkg::DP_MAP_RD;
			S_ADD:         cmd.step = kdll_pkg::DP_ADD;
			S_ADD_LINK:    cmd.step = kdll_pkg::DP_ADD_LINK;
			S_DEL_RD:      cmd.step = kdll_pkg::DP_NODE_RD_MAP;
			S_UNLINK_KEY:  cmd.step = kdll_pkg::DP_UNLINK_KEY;
			S_NODE_RD:     cmd.step = kdll_pkg::DP_NODE_RD_END;
			S_UNLINK_NODE: cmd.step = kdll_pkg::DP_UNLINK_NODE;
			S_GET_KEY:     cmd.step = kdll_pkg::DP_GET_KEY;
			S_OUT:         cmd.step = out_free ? kdll_pkg::DP_OUT : kdll_pkg::DP_NOP;
			default:       cmd.step = kdll_pkg::DP_NOP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			is_add_q    <= 1'b0;
			is_pop_q    <= 1'b0;
			from_head_q <= 1'b0;
			status_q    <= kdll_pkg::STATUS_DONE;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					if (stat.clear_last) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req_valid) begin
						status_q    <= kdll_pkg::STATUS_DONE;
						is_add_q    <= (req_action == kdll_pkg::ACT_ADD);
						is_pop_q    <= (req_action == kdll_pkg::ACT_POP_HEAD) ||
						               (req_action == kdll_pkg::ACT_POP_TAIL);
						from_head_q <= (req_action == kdll_pkg::ACT_POP_HEAD) ||
						               (req_action == kdll_pkg::ACT_READ_HEAD);
						unique case (req_action)
							kdll_pkg::ACT_ADD, kdll_pkg::ACT_DELETE: begin
								state_q <= S_MAP_RD;
							end
							kdll_pkg::ACT_POP_HEAD, kdll_pkg::ACT_POP_TAIL,
							kdll_pkg::ACT_READ_HEAD, kdll_pkg::ACT_READ_TAIL: begin
								if (stat.list_empty) begin
									status_q <= kdll_pkg::STATUS_EMPTY;
									state_q  <= S_OUT;
								end else begin
									state_q <= S_NODE_RD;
								end
							end
							default: begin
								status_q <= kdll_pkg::STATUS_IGNORED;
								state_q  <= S_OUT;
							end
						endcase
					end
				end
				S_MAP_RD: begin
					if (!stat.key_ok) begin
						status_q <= kdll_pkg::STATUS_IGNORED;
						state_q  <= S_OUT;
					end else if (is_add_q) begin
						state_q <= S_ADD;
					end else begin
						state_q <= S_DEL_RD;
					end
				end
				S_ADD: begin
					if (stat.map_hit) begin
						status_q <= kdll_pkg::STATUS_IGNORED;
						state_q  <= S_OUT;
					end else if (stat.slots_full) begin
						status_q <= kdll_pkg::STATUS_FULL;
						state_q  <= S_OUT;
					end else begin
						state_q <= S_ADD_LINK;
					end
				end
				S_DEL_RD: begin
					if (stat.map_hit) begin
						state_q <= S_UNLINK_KEY;
					end else begin
						status_q <= kdll_pkg::STATUS_IGNORED;
						state_q  <= S_OUT;
					end
				end
				S_NODE_RD: begin
					state_q <= is_pop_q ? S_UNLINK_NODE : S_GET_KEY;
				end
				S_ADD_LINK, S_UNLINK_KEY, S_UNLINK_NODE, S_GET_KEY: begin
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

>>> design/keyed_doubly_linked_list.sv
// A successful add runs S_MAP_RD, S_ADD, S_ADD_LINK; a delete S_MAP_RD, S_DEL_RD, S_UNLINK_KEY;
// a pop S_NODE_RD and S_UNLINK_NODE; a read S_NODE_RD and S_GET_KEY. A refused add, an absent key
// or a key out of range ends early, and an empty list or unused code goes straight to S_OUT, which
// registers the result once the output is free. One item is handled at a time; the next request is
// taken in the cycle after the result at the earliest. Reset: arst_n clears the list to empty; the
// block then nulls all min(KEY_RANGE, 1024) key map entries, one a cycle, before its first item.
`default_nettype none

module keyed_doubly_linked_list #(
	parameter int NUM_SLOTS = 1024,
	parameter int KEY_RANGE = 1024
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_ready,
	input  wire kdll_pkg::req_t req,
	output logic                rsp_valid,
	input  wire logic           rsp_ready,
	output kdll_pkg::rsp_t      rsp
);

	// The controller walks each request through its memory steps; the datapath holds the
	// node memories, the key map, the head, tail and free-slot registers and the result register.
	kdll_pkg::cmd_t  cmd;
	kdll_pkg::stat_t stat;

	// The controller sees only the request code; the key is captured by the datapath when the
	// item is accepted.
	kdll_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req_action (req.action),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.stat       (stat),
		.cmd        (cmd)
	);

	// Removal of a node, whether by key or from either end, is one unlink step: the head node
	// always has a null back link and the tail node a null forward link, so both ends fall out
	// of the same neighbour update.
	kdll_datapath #(
		.NUM_SLOTS (NUM_SLOTS),
		.KEY_RANGE (KEY_RANGE)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.key    (req.key),
		.stat   (stat),
		.rsp    (rsp)
	);

endmodule

`default_nettype wire
